[rtl/wtsp_pkg.sv]
// ============================================================================
// World-to-screen projection package
// Shared widths, constants and codes for the projection unit and its
// interfaces, coefficient file, multiplier, divider and checker.
// ============================================================================
package wtsp_pkg;

  // Fixed-point format of all coordinates and coefficients.
  localparam int FRAC_BITS   = 16;
  localparam int FIX_W       = 32;
  localparam int VIEW_W      = 16;

  // Coefficient storage: rows 0, 1 and 3 of the matrix, four columns each.
  localparam int NUM_COEFF   = 12;
  localparam int COEFF_IDX_W = 4;

  // Configuration port.
  localparam int CFG_IDX_W   = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_LEFT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_TOP    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT = CFG_IDX_W'(3);

  localparam logic [VIEW_W-1:0] VIEW_WIDTH_RST  = VIEW_W'(640);
  localparam logic [VIEW_W-1:0] VIEW_HEIGHT_RST = VIEW_W'(480);

  // Item modes.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_PROJECT = 1'b1;

  // Normalized coordinate width after clamping. Any quotient beyond this range
  // saturates the screen value anyway, so clamping keeps results exact.
  localparam int ND_W    = (FRAC_BITS + 19 > 35) ? FRAC_BITS + 19 : 35;
  localparam int MUL_B_W = FIX_W + 1;
  localparam int PROD_W  = ND_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 2;

  // Divider: magnitude of clip * 2^FRAC_BITS over a positive 31-bit divisor.
  localparam int DIVD_W    = FIX_W + FRAC_BITS;
  localparam int DIVS_W    = FIX_W - 1;
  localparam int DIV_CNT_W = $clog2(DIVD_W);

  // Fixed-point constants.
  localparam logic signed [FIX_W-1:0] ONE_FIX     = FIX_W'(longint'(1) << FRAC_BITS);
  localparam logic signed [FIX_W-1:0] NEG_ONE_FIX = -ONE_FIX;
  localparam logic signed [FIX_W-1:0] HALF_FIX    = FIX_W'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [FIX_W-1:0] VIS_MIN_FIX =
    FIX_W'((longint'(1) << FRAC_BITS) / 100);
  localparam logic signed [FIX_W-1:0] FIX_MAX     = FIX_W'((longint'(1) << (FIX_W - 1)) - 1);
  localparam logic signed [FIX_W-1:0] FIX_MIN     = FIX_W'(-(longint'(1) << (FIX_W - 1)));

endpackage

[rtl/wtsp_if.sv]
// ============================================================================
// Projection unit channels
// Valid/ready channels for input items and for screen results.
// ============================================================================
interface wtsp_in_if import wtsp_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [COEFF_IDX_W-1:0]  coeff_index;
  logic signed [FIX_W-1:0] coeff_value;
  logic signed [FIX_W-1:0] point_x;
  logic signed [FIX_W-1:0] point_y;
  logic signed [FIX_W-1:0] point_z;

  modport source (
    output valid, mode, coeff_index, coeff_value, point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, mode, coeff_index, coeff_value, point_x, point_y, point_z,
    output ready
  );
endinterface

interface wtsp_out_if import wtsp_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [FIX_W-1:0] screen_x;
  logic signed [FIX_W-1:0] screen_y;
  logic                    on_screen;

  modport source (
    output valid, screen_x, screen_y, on_screen,
    input  ready
  );
  modport sink (
    input  valid, screen_x, screen_y, on_screen,
    output ready
  );
endinterface

[rtl/wtsp_coeff_rf.sv]
// ============================================================================
// Coefficient register file
// Twelve matrix coefficients, one write port, one read port, cleared on reset.
// ============================================================================
module wtsp_coeff_rf import wtsp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  logic [COEFF_IDX_W-1:0]  waddr_i,
  input  logic signed [FIX_W-1:0] wdata_i,
  input  logic [COEFF_IDX_W-1:0]  raddr_i,
  output logic signed [FIX_W-1:0] rdata_o
);

  logic signed [FIX_W-1:0] coeff_q [NUM_COEFF];

  // Writes to slots beyond the last coefficient are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFF; i++) begin
        coeff_q[i] <= '0;
      end
    end else if (we_i && (waddr_i < COEFF_IDX_W'(NUM_COEFF))) begin
      coeff_q[waddr_i] <= wdata_i;
    end
  end

  // The sequencer only reads valid slots.
  assign rdata_o = (raddr_i < COEFF_IDX_W'(NUM_COEFF)) ? coeff_q[raddr_i] : '0;

endmodule

[rtl/wtsp_mul.sv]
// ============================================================================
// Shared multiplier
// Signed multiplier with a registered product, used for the matrix terms
// and for the viewport scaling.
// ============================================================================
module wtsp_mul import wtsp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [ND_W-1:0]   a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  // Product register; holds its value while the unit is not in use.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

[rtl/wtsp_div.sv]
// ============================================================================
// Serial divider
// Restoring division of clip * 2^FRAC_BITS by a positive clip w, one quotient
// bit per cycle, truncated toward zero and clamped to the normalized range.
// ============================================================================
module wtsp_div import wtsp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [FIX_W-1:0] num_i,
  input  logic [DIVS_W-1:0]       den_i,
  output logic                    done_o,
  output logic signed [ND_W-1:0]  quot_o
);

  localparam logic [DIVD_W-1:0] QMAX = DIVD_W'((longint'(1) << (ND_W - 1)) - 1);

  logic                   busy_q;
  logic                   fix_q;
  logic                   done_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic                   neg_q;
  logic [DIVS_W-1:0]      rem_q;
  logic [DIVD_W-1:0]      quo_q;
  logic signed [ND_W-1:0] quot_q;

  logic [FIX_W-1:0]       num_mag;
  logic [DIVS_W:0]        trial;
  logic                   trial_ge;
  logic [DIVD_W-1:0]      quo_clamped;
  logic signed [ND_W-1:0] quo_nd;

  assign num_mag     = num_i[FIX_W-1] ? (~num_i + 1'b1) : num_i;
  assign trial       = {rem_q, quo_q[DIVD_W-1]};
  assign trial_ge    = (trial >= {1'b0, den_i});
  assign quo_clamped = (quo_q > QMAX) ? QMAX : quo_q;
  assign quo_nd      = ND_W'(quo_clamped);

  // Control: iteration count and the one-cycle done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fix_q;
      fix_q  <= busy_q && !start_i && (cnt_q == DIV_CNT_W'(DIVD_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIVD_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: shift in one dividend bit per cycle, then apply sign.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[FIX_W-1];
      rem_q <= '0;
      quo_q <= {num_mag, {FRAC_BITS{1'b0}}};
    end else if (busy_q) begin
      rem_q <= trial_ge ? DIVS_W'(trial - {1'b0, den_i}) : trial[DIVS_W-1:0];
      quo_q <= {quo_q[DIVD_W-2:0], trial_ge};
    end
    if (fix_q) begin
      quot_q <= neg_q ? -quo_nd : quo_nd;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[rtl/world_to_screen_projection_unit.sv]
// A visible project item runs the nine matrix products through the shared multiplier,
// adds the translation coefficients without it, and then runs two serial
// divisions of DIVD_W quotient bits each, which take most of its time.
// An off-screen point skips the divisions; a coefficient load gives no result. The input
// is ready again in the cycle the result turns valid, unless an earlier result waits.
// Reset clears the coefficients to zero and restores the viewport defaults.
// ============================================================================
// World-to-screen projection unit
// Projects a world point through three matrix rows, divides by clip w and
// maps the result to window pixel coordinates in Q16.16.
// ============================================================================
module world_to_screen_projection_unit import wtsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [VIEW_W-1:0]    cfg_data_i,
  wtsp_in_if.sink              in_ch,
  wtsp_out_if.source           out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BIAS,
    ST_MUL,
    ST_ACC,
    ST_CLIP,
    ST_VIS,
    ST_DIV,
    ST_SCALE,
    ST_SUM,
    ST_FIN,
    ST_DONE
  } state_e;

  function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(FIX_MAX);
    lo = ACC_W'(FIX_MIN);
    if (v > hi) begin
      return FIX_MAX;
    end else if (v < lo) begin
      return FIX_MIN;
    end else begin
      return v[FIX_W-1:0];
    end
  endfunction

  // Control and result registers.
  state_e                  state_q;
  logic [1:0]              row_q;
  logic [1:0]              col_q;
  logic                    axis_q;
  logic                    out_valid_q;
  logic signed [FIX_W-1:0] out_x_q;
  logic signed [FIX_W-1:0] out_y_q;
  logic                    out_on_q;

  // Configuration registers.
  logic signed [VIEW_W-1:0] view_left_q;
  logic signed [VIEW_W-1:0] view_top_q;
  logic [VIEW_W-1:0]        view_width_q;
  logic [VIEW_W-1:0]        view_height_q;

  // Datapath registers.
  logic signed [FIX_W-1:0] pt_q   [3];
  logic signed [FIX_W-1:0] clip_q [3];
  logic signed [ACC_W-1:0] acc_q;
  logic signed [FIX_W-1:0] res_x_q;
  logic signed [FIX_W-1:0] res_y_q;
  logic                    res_on_q;

  // Datapath signals.
  logic                     in_xfer;
  logic                     rf_we;
  logic [COEFF_IDX_W-1:0]   rf_raddr;
  logic signed [FIX_W-1:0]  coeff;
  logic signed [FIX_W-1:0]  pt_sel;
  logic                     mul_en;
  logic signed [ND_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  one_ext;
  logic [VIEW_W-1:0]        dim;
  logic signed [ACC_W-1:0]  dim_s;
  logic signed [ACC_W-1:0]  sum_x;
  logic signed [ACC_W-1:0]  sum_y;
  logic signed [VIEW_W-1:0] org;
  logic signed [ACC_W-1:0]  org_s;
  logic signed [ACC_W-1:0]  fin;
  logic signed [FIX_W-1:0]  fin_sat;
  logic signed [FIX_W-1:0]  clip_sat;
  logic                     visible;
  logic                     div_start;
  logic signed [FIX_W-1:0]  div_num;
  logic                     div_done;
  logic signed [ND_W-1:0]   div_quot;
  logic                     out_free;

  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_q || out_ch.ready;

  // Coefficient storage: loads write straight from the input channel.
  assign rf_we    = in_xfer && (in_ch.mode == MODE_LOAD);
  assign rf_raddr = (state_q == ST_BIAS) ? {row_q, 2'd3} : {row_q, col_q};

  wtsp_coeff_rf u_coeff_rf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (rf_we),
    .waddr_i (in_ch.coeff_index),
    .wdata_i (in_ch.coeff_value),
    .raddr_i (rf_raddr),
    .rdata_o (coeff)
  );

  // Shared multiplier operands: matrix terms, or normalized coordinate times size.
  assign pt_sel = pt_q[col_q];
  assign dim    = axis_q ? view_height_q : view_width_q;
  assign mul_en = (state_q == ST_MUL) || (state_q == ST_SCALE);

  always_comb begin
    if (state_q == ST_SCALE) begin
      mul_a = div_quot;
      mul_b = MUL_B_W'(dim);
    end else begin
      mul_a = ND_W'(pt_sel);
      mul_b = MUL_B_W'(coeff);
    end
  end

  wtsp_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Rounded matrix term: floor((prod + half) / 2^FRAC_BITS).
  assign prod_rnd = prod + PROD_W'(HALF_FIX);
  assign term     = ACC_W'(prod_rnd >>> FRAC_BITS);
  assign clip_sat = sat_fix(acc_q);

  // Viewport mapping before the halving.
  assign prod_ext = ACC_W'(prod);
  assign one_ext  = ACC_W'(ONE_FIX);
  assign dim_s    = ACC_W'({dim, {FRAC_BITS{1'b0}}});
  assign sum_x    = dim_s + prod_ext + one_ext;
  assign sum_y    = dim_s - prod_ext - one_ext;

  // Halve with floor, add the window origin and saturate.
  assign org     = axis_q ? view_top_q : view_left_q;
  assign org_s   = ACC_W'(org) <<< FRAC_BITS;
  assign fin     = (acc_q >>> 1) + org_s;
  assign fin_sat = sat_fix(fin);

  assign visible = (clip_q[2] > VIS_MIN_FIX);

  // Divider for x after the visibility check, for y after x is finished.
  assign div_start = ((state_q == ST_VIS) && visible) ||
                     ((state_q == ST_FIN) && !axis_q);
  assign div_num   = (state_q == ST_FIN) ? clip_q[1] : clip_q[0];

  wtsp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (clip_q[2][DIVS_W-1:0]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Sequencer with registered result outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_on_q    <= 1'b0;
    end else begin
      if (out_valid_q && out_ch.ready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer && (in_ch.mode == MODE_PROJECT)) begin
            row_q   <= '0;
            col_q   <= '0;
            axis_q  <= 1'b0;
            state_q <= ST_BIAS;
          end
        end
        ST_BIAS: begin
          col_q   <= '0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (col_q == 2'd2) begin
            state_q <= ST_CLIP;
          end else begin
            col_q   <= col_q + 1'b1;
            state_q <= ST_MUL;
          end
        end
        ST_CLIP: begin
          if (row_q == 2'd2) begin
            state_q <= ST_VIS;
          end else begin
            row_q   <= row_q + 1'b1;
            state_q <= ST_BIAS;
          end
        end
        ST_VIS: begin
          state_q <= visible ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_x_q     <= res_x_q;
            out_y_q     <= res_y_q;
            out_on_q    <= res_on_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Working registers of the arithmetic, steered by the sequencer.
  always_ff @(posedge clk_i) begin
    if (in_xfer && (in_ch.mode == MODE_PROJECT)) begin
      pt_q[0] <= in_ch.point_x;
      pt_q[1] <= in_ch.point_y;
      pt_q[2] <= in_ch.point_z;
    end
    case (state_q)
      ST_BIAS: acc_q <= ACC_W'(coeff);
      ST_ACC:  acc_q <= acc_q + term;
      ST_CLIP: clip_q[row_q] <= clip_sat;
      ST_VIS: begin
        res_on_q <= visible;
        if (!visible) begin
          res_x_q <= NEG_ONE_FIX;
          res_y_q <= NEG_ONE_FIX;
        end
      end
      ST_SUM:  acc_q <= axis_q ? sum_y : sum_x;
      ST_FIN: begin
        if (axis_q) begin
          res_y_q <= fin_sat;
        end else begin
          res_x_q <= fin_sat;
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_left_q   <= '0;
      view_top_q    <= '0;
      view_width_q  <= VIEW_WIDTH_RST;
      view_height_q <= VIEW_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VIEW_LEFT:   view_left_q   <= cfg_data_i;
        CFG_VIEW_TOP:    view_top_q    <= cfg_data_i;
        CFG_VIEW_WIDTH:  view_width_q  <= cfg_data_i;
        CFG_VIEW_HEIGHT: view_height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.screen_x  = out_x_q;
  assign out_ch.screen_y  = out_y_q;
  assign out_ch.on_screen = out_on_q;

endmodule

[rtl/wtsp_checker.sv]
// ============================================================================
// Projection unit checker
// Port-level assertions on transfers and results, bound to the top level.
// ============================================================================
module wtsp_checker import wtsp_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    in_mode_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic signed [FIX_W-1:0] out_x_i,
  input logic signed [FIX_W-1:0] out_y_i,
  input logic                    out_on_i
);

  // An off-screen result always reports minus one in both coordinates.
  a_off_screen_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_on_i) |-> (out_x_i == NEG_ONE_FIX) && (out_y_i == NEG_ONE_FIX))
    else $error("off-screen result without -1.0 coordinates");

  // The unit takes nothing new while a projection is in progress.
  a_busy_after_project: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_mode_i == MODE_PROJECT)) |=> !in_ready_i)
    else $error("input ready right after a project transfer");

  // A coefficient load never produces a result.
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_mode_i == MODE_LOAD) && !out_valid_i) |=> !out_valid_i)
    else $error("result appeared after a coefficient load");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      out_valid_i && $stable(out_x_i) && $stable(out_y_i) && $stable(out_on_i))
    else $error("stalled result changed");

endmodule

bind world_to_screen_projection_unit wtsp_checker u_wtsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .in_mode_i   (in_ch.mode),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_x_i     (out_ch.screen_x),
  .out_y_i     (out_ch.screen_y),
  .out_on_i    (out_ch.on_screen)
);

[bench/tb_world_to_screen_projection_unit.sv]
`timescale 1ns / 100ps
// ============================================================================
// Projection unit testbench
// Drives coefficient loads, project points and viewport settings into the
// projection unit, predicts each screen point in fixed point and checks
// every result transfer against the oldest pending prediction.
// ============================================================================
module tb_world_to_screen_projection_unit;
  import wtsp_pkg::*;

  localparam longint FIX_ONE         = longint'(1) << FRAC_BITS;
  localparam int     PHASES          = 8;
  localparam int     ITEMS_PER_PHASE = 66;
  localparam int     DRAIN_CYCLES    = 160;
  localparam int     WATCHDOG_CYCLES = 4000;
  localparam int     REPORT_LIMIT    = 10;

  // Matrix layout: rows x, y and w, columns x, y, z and translation.
  localparam int NUM_COLS = 4;
  localparam int ROW_X    = 0;
  localparam int ROW_Y    = 1;
  localparam int ROW_W    = 2;
  localparam int COL_Z    = 2;
  localparam int COL_T    = 3;

  localparam logic [COEFF_IDX_W-1:0] SLOT_XX     = COEFF_IDX_W'(0);
  localparam logic [COEFF_IDX_W-1:0] SLOT_YY     = COEFF_IDX_W'(5);
  localparam logic [COEFF_IDX_W-1:0] SLOT_WX     = COEFF_IDX_W'(8);
  localparam logic [COEFF_IDX_W-1:0] SLOT_WY     = COEFF_IDX_W'(9);
  localparam logic [COEFF_IDX_W-1:0] SLOT_WZ     = COEFF_IDX_W'(10);
  localparam logic [COEFF_IDX_W-1:0] SLOT_WT     = COEFF_IDX_W'(11);
  localparam logic [COEFF_IDX_W-1:0] SLOT_BAD_LO = COEFF_IDX_W'(NUM_COEFF);
  localparam logic [COEFF_IDX_W-1:0] SLOT_BAD_HI = '1;

  typedef struct packed {
    logic                    mode;
    logic [COEFF_IDX_W-1:0]  slot;
    logic signed [FIX_W-1:0] coeff;
    logic signed [FIX_W-1:0] px;
    logic signed [FIX_W-1:0] py;
    logic signed [FIX_W-1:0] pz;
  } xform_item_t;

  typedef struct packed {
    logic signed [FIX_W-1:0] sx;
    logic signed [FIX_W-1:0] sy;
    logic                    on_screen;
  } screen_pt_t;

  // A directed row either carries a known off-screen answer or is predicted.
  typedef struct packed {
    xform_item_t item;
    logic        off_known;
  } dir_row_t;

  localparam screen_pt_t OFF_SCREEN_PT = {NEG_ONE_FIX, NEG_ONE_FIX, 1'b0};

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [VIEW_W-1:0]    cfg_data_i;

  wtsp_in_if  in_ch ();
  wtsp_out_if out_ch ();

  world_to_screen_projection_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Predictor state: stored coefficients and viewport registers.
  logic signed [FIX_W-1:0]  coeff_model [NUM_COEFF];
  logic signed [VIEW_W-1:0] view_left_m;
  logic signed [VIEW_W-1:0] view_top_m;
  logic [VIEW_W-1:0]        view_width_m;
  logic [VIEW_W-1:0]        view_height_m;

  screen_pt_t pending_points [$];
  int         mismatches     = 0;
  int         items_sent     = 0;
  int         quiet_cycles   = 0;
  int         src_idle_pct   = 0;
  int         sink_stall_pct = 0;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint sat_fix(input longint v);
    if (v > longint'(FIX_MAX)) return longint'(FIX_MAX);
    if (v < longint'(FIX_MIN)) return longint'(FIX_MIN);
    return v;
  endfunction

  // One clip coordinate: rounded products plus translation, saturated.
  function automatic longint clip_row(input int row, input longint p0, input longint p1,
                                      input longint p2);
    longint acc;
    acc = longint'(coeff_model[row*NUM_COLS + COL_T]);
    acc += (longint'(coeff_model[row*NUM_COLS])     * p0 + FIX_ONE/2) >>> FRAC_BITS;
    acc += (longint'(coeff_model[row*NUM_COLS + 1]) * p1 + FIX_ONE/2) >>> FRAC_BITS;
    acc += (longint'(coeff_model[row*NUM_COLS + 2]) * p2 + FIX_ONE/2) >>> FRAC_BITS;
    return sat_fix(acc);
  endfunction

  // Updates the coefficient copy for a load, or computes the screen point.
  // Returns 1 when the item produces a result.
  function automatic bit project_point(input xform_item_t it, output screen_pt_t pt);
    longint px, py, pz, cx, cy, cw, nx, ny, wd, ht, sx, sy;
    pt = OFF_SCREEN_PT;
    if (it.mode == MODE_LOAD) begin
      if (it.slot < NUM_COEFF) coeff_model[it.slot] = it.coeff;
      return 1'b0;
    end
    px = longint'(it.px);
    py = longint'(it.py);
    pz = longint'(it.pz);
    cx = clip_row(ROW_X, px, py, pz);
    cy = clip_row(ROW_Y, px, py, pz);
    cw = clip_row(ROW_W, px, py, pz);
    // Visible only when w is above 0.01 exactly.
    if (cw * 100 > FIX_ONE) begin
      wd = longint'(view_width_m);
      ht = longint'(view_height_m);
      nx = (cx * FIX_ONE) / cw;
      ny = (cy * FIX_ONE) / cw;
      sx = ((wd*FIX_ONE + nx*wd + FIX_ONE) >>> 1) + longint'(view_left_m) * FIX_ONE;
      sy = ((ht*FIX_ONE - ny*ht - FIX_ONE) >>> 1) + longint'(view_top_m) * FIX_ONE;
      pt.sx        = FIX_W'(sat_fix(sx));
      pt.sy        = FIX_W'(sat_fix(sy));
      pt.on_screen = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic xform_item_t mk_item(input logic mode, input logic [COEFF_IDX_W-1:0] slot,
                                          input logic signed [FIX_W-1:0] coeff,
                                          input logic signed [FIX_W-1:0] px,
                                          input logic signed [FIX_W-1:0] py,
                                          input logic signed [FIX_W-1:0] pz);
    return {mode, slot, coeff, px, py, pz};
  endfunction

  // Uniform signed value in [-span, span].
  function automatic logic signed [FIX_W-1:0] rand_fix(input longint span);
    return FIX_W'(longint'($urandom_range(0, 32'(2*span))) - span);
  endfunction

  // Coefficients of a plausible perspective matrix, so most points land in view.
  function automatic logic signed [FIX_W-1:0] scene_coeff(input int s);
    int row;
    int col;
    row = s / NUM_COLS;
    col = s % NUM_COLS;
    if (row != ROW_W) return (col == COL_T) ? rand_fix(8*FIX_ONE) : rand_fix(2*FIX_ONE);
    if (col == COL_T) begin
      if ($urandom_range(0, 7) == 0)
        return FIX_W'($urandom_range(VIS_MIN_FIX - 40, VIS_MIN_FIX + 40));
      return FIX_W'($urandom_range(32'(FIX_ONE/2), 32'(8*FIX_ONE)));
    end
    return (col == COL_Z) ? rand_fix(FIX_ONE) : rand_fix(FIX_ONE/4);
  endfunction

  // Drives one item, waits for its transfer and records the prediction.
  task automatic send_item(input xform_item_t it, input bit off_known);
    screen_pt_t pt;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid       = 1'b1;
    in_ch.mode        = it.mode;
    in_ch.coeff_index = it.slot;
    in_ch.coeff_value = it.coeff;
    in_ch.point_x     = it.px;
    in_ch.point_y     = it.py;
    in_ch.point_z     = it.pz;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (project_point(it, pt)) pending_points.push_back(off_known ? OFF_SCREEN_PT : pt);
    if (!(it.mode == MODE_LOAD && it.slot >= NUM_COEFF)) items_sent++;
  endtask

  // Stops the input side and waits until the unit has gone idle.
  task automatic quiesce();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [VIEW_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    case (idx)
      CFG_VIEW_LEFT:   view_left_m   = data;
      CFG_VIEW_TOP:    view_top_m    = data;
      CFG_VIEW_WIDTH:  view_width_m  = data;
      CFG_VIEW_HEIGHT: view_height_m = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Viewport for each phase: reset values, both extremes, zero size, then random.
  task automatic configure_phase(input int k);
    logic [VIEW_W-1:0] l, t, w, h;
    case (k)
      0: begin
        l = '0; t = '0; w = VIEW_WIDTH_RST; h = VIEW_HEIGHT_RST;
      end
      1: begin
        l = {1'b1, {(VIEW_W-1){1'b0}}}; t = {1'b0, {(VIEW_W-1){1'b1}}}; w = '1; h = '1;
      end
      2: begin
        l = {1'b0, {(VIEW_W-1){1'b1}}}; t = {1'b1, {(VIEW_W-1){1'b0}}};
        w = VIEW_W'(1); h = VIEW_W'(1);
      end
      3: begin
        l = '0; t = '0; w = '0; h = '0;
      end
      default: begin
        l = VIEW_W'($urandom); t = VIEW_W'($urandom);
        w = VIEW_W'($urandom_range(1, 2048)); h = VIEW_W'($urandom_range(1, 2048));
      end
    endcase
    write_cfg(CFG_VIEW_LEFT, l);
    write_cfg(CFG_VIEW_TOP, t);
    write_cfg(CFG_VIEW_WIDTH, w);
    write_cfg(CFG_VIEW_HEIGHT, h);
    // A write to an unused index must leave the viewport alone.
    write_cfg(CFG_IDX_W'($urandom_range(int'(CFG_VIEW_HEIGHT) + 1, (1 << CFG_IDX_W) - 1)),
              VIEW_W'($urandom));
  endtask

  // A matrix load, full or partial, followed by a few points to project.
  task automatic run_scene();
    int n;
    int s;
    if ($urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        s = $urandom_range(0, NUM_COEFF - 1);
        send_item(mk_item(MODE_LOAD, COEFF_IDX_W'(s), scene_coeff(s), $urandom, $urandom,
                          $urandom), 1'b0);
      end
    end else begin
      for (s = 0; s < NUM_COEFF; s++)
        send_item(mk_item(MODE_LOAD, COEFF_IDX_W'(s), scene_coeff(s), $urandom, $urandom,
                          $urandom), 1'b0);
    end
    n = $urandom_range(2, 6);
    repeat (n)
      send_item(mk_item(MODE_PROJECT, COEFF_IDX_W'($urandom), $urandom, rand_fix(16*FIX_ONE),
                        rand_fix(16*FIX_ONE), rand_fix(16*FIX_ONE)), 1'b0);
  endtask

  // Result side: random stalls, set at the falling edge.
  always @(negedge clk_i) begin
    out_ch.ready = ($urandom_range(0, 99) >= sink_stall_pct);
  end

  task automatic report_mismatch(input string what, input screen_pt_t want,
                                 input screen_pt_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t %s: expected x=%h y=%h on=%b, got x=%h y=%h on=%b", $time, what,
               want.sx, want.sy, want.on_screen, got.sx, got.sy, got.on_screen);
  endtask

  // Compare each result transfer with the oldest pending point.
  always @(posedge clk_i) begin : check_results
    screen_pt_t want;
    screen_pt_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = {out_ch.screen_x, out_ch.screen_y, out_ch.on_screen};
      if (pending_points.size() == 0) begin
        report_mismatch("result with nothing pending", '0, got);
      end else begin
        want = pending_points.pop_front();
        if (got.sx !== want.sx || got.sy !== want.sy || got.on_screen !== want.on_screen)
          report_mismatch("screen point mismatch", want, got);
      end
    end
  end

  // Watchdog: too many cycles without any transfer ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t watchdog expired with %0d points pending", $time, pending_points.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, then random phases per viewport.
  initial begin : stimulus
    dir_row_t directed [$];
    int       phase_goal;

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_LOAD;
    in_ch.coeff_index = '0;
    in_ch.coeff_value = '0;
    in_ch.point_x     = '0;
    in_ch.point_y     = '0;
    in_ch.point_z     = '0;
    foreach (coeff_model[i]) coeff_model[i] = '0;
    view_left_m   = '0;
    view_top_m    = '0;
    view_width_m  = VIEW_WIDTH_RST;
    view_height_m = VIEW_HEIGHT_RST;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Cleared matrix gives w of zero, so every point is off screen.
    directed.push_back({mk_item(MODE_PROJECT, '0, $urandom, FIX_MAX, FIX_MAX, FIX_MAX), 1'b1});
    directed.push_back({mk_item(MODE_PROJECT, '1, $urandom, FIX_MIN, FIX_MIN, FIX_MIN), 1'b1});
    // Loads to slots past the matrix are dropped.
    directed.push_back({mk_item(MODE_LOAD, SLOT_BAD_HI, ONE_FIX, $urandom, $urandom, $urandom),
                        1'b0});
    directed.push_back({mk_item(MODE_LOAD, SLOT_BAD_LO, ONE_FIX, $urandom, $urandom, $urandom),
                        1'b0});
    directed.push_back({mk_item(MODE_PROJECT, '0, '0, ONE_FIX, ONE_FIX, ONE_FIX), 1'b1});
    // w just at and just above the visibility threshold.
    directed.push_back({mk_item(MODE_LOAD, SLOT_WT, VIS_MIN_FIX, '0, '0, '0), 1'b0});
    directed.push_back({mk_item(MODE_PROJECT, '0, '0, '0, '0, '0), 1'b1});
    directed.push_back({mk_item(MODE_LOAD, SLOT_WT, VIS_MIN_FIX + 1, '0, '0, '0), 1'b0});
    directed.push_back({mk_item(MODE_PROJECT, '0, '0, '0, '0, '0), 1'b0});
    // Identity-like matrix, then points that saturate the screen values.
    directed.push_back({mk_item(MODE_LOAD, SLOT_XX, ONE_FIX, '0, '0, '0), 1'b0});
    directed.push_back({mk_item(MODE_LOAD, SLOT_YY, ONE_FIX, '0, '0, '0), 1'b0});
    directed.push_back({mk_item(MODE_LOAD, SLOT_WT, ONE_FIX, '0, '0, '0), 1'b0});
    directed.push_back({mk_item(MODE_PROJECT, '0, '0, HALF_FIX, -HALF_FIX, ONE_FIX), 1'b0});
    directed.push_back({mk_item(MODE_PROJECT, '0, '0, FIX_MAX, FIX_MIN, '0), 1'b0});
    directed.push_back({mk_item(MODE_PROJECT, '0, '0, FIX_MIN, FIX_MAX, '0), 1'b0});
    // Negative w is off screen.
    directed.push_back({mk_item(MODE_LOAD, SLOT_WT, FIX_MIN, '0, '0, '0), 1'b0});
    directed.push_back({mk_item(MODE_PROJECT, '0, '0, '0, '0, '0), 1'b1});
    // Extreme coefficients drive clip w into saturation on both sides.
    directed.push_back({mk_item(MODE_LOAD, SLOT_WT, '0, '0, '0, '0), 1'b0});
    directed.push_back({mk_item(MODE_LOAD, SLOT_WZ, FIX_MAX, '0, '0, '0), 1'b0});
    directed.push_back({mk_item(MODE_PROJECT, '0, '0, '0, '0, FIX_MAX), 1'b0});
    directed.push_back({mk_item(MODE_PROJECT, '0, '0, '0, '0, FIX_MIN), 1'b1});
    directed.push_back({mk_item(MODE_LOAD, SLOT_WZ, FIX_MIN, '0, '0, '0), 1'b0});
    directed.push_back({mk_item(MODE_PROJECT, '0, '0, '0, '0, FIX_MIN), 1'b0});

    foreach (directed[i]) send_item(directed[i].item, directed[i].off_known);

    for (int k = 0; k < PHASES; k++) begin
      quiesce();
      configure_phase(k);
      case (k % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 58; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 58; end
        default: begin src_idle_pct = 33; sink_stall_pct = 33; end
      endcase
      phase_goal = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_goal) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: run_scene();
          6: send_item(mk_item(MODE_LOAD, COEFF_IDX_W'($urandom), $urandom, $urandom,
                               $urandom, $urandom), 1'b0);
          7: send_item(mk_item(MODE_PROJECT, COEFF_IDX_W'($urandom), $urandom, $urandom,
                               $urandom, $urandom), 1'b0);
          8: begin
            // Probe the visibility threshold with a pure translation in w.
            send_item(mk_item(MODE_LOAD, SLOT_WX, '0, $urandom, $urandom, $urandom), 1'b0);
            send_item(mk_item(MODE_LOAD, SLOT_WY, '0, $urandom, $urandom, $urandom), 1'b0);
            send_item(mk_item(MODE_LOAD, SLOT_WZ, '0, $urandom, $urandom, $urandom), 1'b0);
            send_item(mk_item(MODE_LOAD, SLOT_WT,
                              FIX_W'($urandom_range(VIS_MIN_FIX - 3, VIS_MIN_FIX + 3)),
                              $urandom, $urandom, $urandom), 1'b0);
            send_item(mk_item(MODE_PROJECT, COEFF_IDX_W'($urandom), $urandom,
                              rand_fix(FIX_ONE/64), rand_fix(FIX_ONE/64), $urandom), 1'b0);
          end
          default: send_item(mk_item(MODE_PROJECT, COEFF_IDX_W'($urandom), $urandom,
                                     rand_fix(16*FIX_ONE), rand_fix(16*FIX_ONE),
                                     rand_fix(16*FIX_ONE)), 1'b0);
        endcase
      end
    end

    quiesce();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
